FILE: rtl/etpq_pkg.sv
// Shared types and codes for the event-time priority queue.
package etpq_pkg;

  // Operation codes carried on the request channel
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2,
    ST_RSVD       = 2'd3
  } status_t;

  // One stored event: sort key plus task fields
  typedef struct packed {
    logic        kind;
    logic [15:0] etime;
    logic [7:0]  task_number;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic [7:0]  priority_lvl;
  } event_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

FILE: rtl/etpq_req_if.sv
// Request channel: one push or pop with its event fields.
interface etpq_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        event_kind;
  logic [15:0] event_time;
  logic [7:0]  task_number;
  logic [15:0] task_burst;
  logic [15:0] task_arrival;
  logic [7:0]  task_priority;

  modport source (
    output valid, func, event_kind, event_time, task_number, task_burst,
           task_arrival, task_priority,
    input  ready
  );
  modport sink (
    input  valid, func, event_kind, event_time, task_number, task_burst,
           task_arrival, task_priority,
    output ready
  );
endinterface

FILE: rtl/etpq_rsp_if.sv
// Response channel: status, popped event and queue flags.
interface etpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        popped_kind;
  logic [15:0] popped_time;
  logic [7:0]  popped_task;
  logic [15:0] popped_burst;
  logic [15:0] popped_arrival;
  logic [7:0]  popped_priority;
  logic        queue_empty;
  logic        queue_full;

  modport source (
    output valid, status, popped_kind, popped_time, popped_task, popped_burst,
           popped_arrival, popped_priority, queue_empty, queue_full,
    input  ready
  );
  modport sink (
    input  valid, status, popped_kind, popped_time, popped_task, popped_burst,
           popped_arrival, popped_priority, queue_empty, queue_full,
    output ready
  );
endinterface

FILE: rtl/etpq_cell.sv
// One slot of the sorted queue: compares against a new event and shifts.
module etpq_cell (
  input  logic                 clk,
  input  etpq_pkg::cell_ctrl_t ctrl,
  input  logic                 active,
  input  etpq_pkg::event_t     new_event,
  input  etpq_pkg::event_t     left_event,
  input  logic                 left_after,
  input  etpq_pkg::event_t     right_event,
  output etpq_pkg::event_t     slot,
  output logic                 after
);

  etpq_pkg::event_t slot_next;

  // New event stays behind this slot: later time, or same time and lower kind
  assign after = active &&
                 ((new_event.etime > slot.etime) ||
                  ((new_event.etime == slot.etime) && (new_event.kind < slot.kind)));

  // Keep, take the new event, take the left neighbor, or take the right one
  always_comb begin
    slot_next = slot;
    if (ctrl.push) begin
      if (!after) begin
        slot_next = left_after ? new_event : left_event;
      end
    end else if (ctrl.pop) begin
      slot_next = right_event;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

FILE: rtl/event_time_priority_queue_unit.sv
// Event-time priority queue: top level with the cell row and response register.
//
// Usage: requests arrive on req (valid/ready). func selects push or pop.
// A push inserts the event into a row of DEPTH cells kept sorted by
// ascending time, higher kind first among equal times, newest first among
// equal keys. A pop returns the head event. Every request gives exactly one
// response on rsp carrying a status, the popped event (zero unless a pop
// succeeded) and the empty/full flags after the operation.
// A pop on an empty queue reports status 1; a push on a full queue is
// dropped and reports status 2.
// The response is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless rsp stalls; every cell compares
// against the new event in parallel and hands its entry to a neighbor in the same cycle.
// Stall: req.ready is high while the response register is empty or being
// taken, so a stalled receiver holds the response and blocks only the next
// request. Reset clears the occupancy count and the response valid; slot
// contents are not cleared and are never read before being written.
module event_time_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  etpq_req_if.sink   req,
  etpq_rsp_if.source rsp
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0]     occupancy;
  logic [OCC_W-1:0]     occupancy_next;
  logic                 accept;
  logic                 is_empty;
  logic                 is_full;
  etpq_pkg::cell_ctrl_t ctrl;
  etpq_pkg::event_t     new_event;
  etpq_pkg::event_t     slots   [DEPTH];
  logic                 afters  [DEPTH];
  etpq_pkg::status_t    status_next;
  etpq_pkg::event_t     popped_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_empty  = (occupancy == '0);
  assign is_full   = (occupancy == OCC_W'(DEPTH));

  assign new_event.kind         = req.event_kind;
  assign new_event.etime        = req.event_time;
  assign new_event.task_number  = req.task_number;
  assign new_event.burst        = req.task_burst;
  assign new_event.arrival      = req.task_arrival;
  assign new_event.priority_lvl = req.task_priority;

  // Decode the request into cell commands, status and new occupancy
  always_comb begin
    ctrl           = '0;
    occupancy_next = occupancy;
    status_next    = etpq_pkg::ST_OK;
    popped_next    = '0;
    if (accept) begin
      if (req.func == etpq_pkg::FUNC_PUSH) begin
        if (is_full) begin
          status_next = etpq_pkg::ST_PUSH_FULL;
        end else begin
          ctrl.push      = 1'b1;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end else begin
        if (is_empty) begin
          status_next = etpq_pkg::ST_POP_EMPTY;
        end else begin
          ctrl.pop       = 1'b1;
          popped_next    = slots[0];
          occupancy_next = occupancy - OCC_W'(1);
        end
      end
    end
  end

  // Row of cells; cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    etpq_pkg::event_t left_event;
    etpq_pkg::event_t right_event;
    logic             left_after;
    logic             active;

    assign active = (OCC_W'(i) < occupancy);

    if (i == 0) begin : g_head
      assign left_event = new_event;
      assign left_after = 1'b1;
    end else begin : g_body
      assign left_event = slots[i-1];
      assign left_after = afters[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_event = '0;
    end else begin : g_inner
      assign right_event = slots[i+1];
    end

    etpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .active      (active),
      .new_event   (new_event),
      .left_event  (left_event),
      .left_after  (left_after),
      .right_event (right_event),
      .slot        (slots[i]),
      .after       (afters[i])
    );
  end

  // Occupancy count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp.valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status          <= status_next;
      rsp.popped_kind     <= popped_next.kind;
      rsp.popped_time     <= popped_next.etime;
      rsp.popped_task     <= popped_next.task_number;
      rsp.popped_burst    <= popped_next.burst;
      rsp.popped_arrival  <= popped_next.arrival;
      rsp.popped_priority <= popped_next.priority_lvl;
      rsp.queue_empty     <= (occupancy_next == '0);
      rsp.queue_full      <= (occupancy_next == OCC_W'(DEPTH));
    end
  end

endmodule

FILE: dv/event_time_priority_queue_unit_tb.sv
// Self-checking testbench for the event-time priority queue unit.
module event_time_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_LEN    = 80;
  localparam int DRAIN_WAIT  = 10;

  typedef struct packed {
    logic             func;
    etpq_pkg::event_t ev;
  } request_t;

  typedef struct packed {
    etpq_pkg::status_t status;
    etpq_pkg::event_t  ev;
    logic              empty;
    logic              full;
  } reply_t;

  logic clk;
  logic rst;

  etpq_req_if req_ch();
  etpq_rsp_if rsp_ch();

  event_time_priority_queue_unit #(.DEPTH(QDEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Sorted event store mirrored from accepted requests, head in slot 0
  etpq_pkg::event_t ev_slot [QDEPTH];
  int     ev_count;
  reply_t reply_backlog[$];

  // Pacing controls shared with the sender and receiver processes
  bit send_gaps;
  bit take_gaps;
  int hold_len;

  int mismatches;
  int push_count;
  int pop_count;
  int drop_count;
  int empty_pop_count;
  int full_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and idle levels on the request inputs
  initial begin
    rst = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.func          = etpq_pkg::FUNC_PUSH;
    req_ch.event_kind    = 1'b0;
    req_ch.event_time    = '0;
    req_ch.task_number   = '0;
    req_ch.task_burst    = '0;
    req_ch.task_arrival  = '0;
    req_ch.task_priority = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
  end

  // Apply one request to the mirrored store and return the reply it earns
  function automatic reply_t event_queue_step(request_t r);
    reply_t rep;
    int     pos;
    int     i;
    rep = '0;
    rep.status = etpq_pkg::ST_OK;
    if (r.func == etpq_pkg::FUNC_PUSH) begin
      push_count++;
      if (ev_count >= QDEPTH) begin
        rep.status = etpq_pkg::ST_PUSH_FULL;
        drop_count++;
      end else begin
        // new event stays behind earlier times and higher kinds at equal time
        pos = 0;
        while (pos < ev_count &&
               (r.ev.etime > ev_slot[pos].etime ||
                (r.ev.etime == ev_slot[pos].etime && r.ev.kind < ev_slot[pos].kind)))
          pos++;
        for (i = ev_count; i > pos; i--)
          ev_slot[i] = ev_slot[i-1];
        ev_slot[pos] = r.ev;
        ev_count++;
      end
    end else begin
      pop_count++;
      if (ev_count == 0) begin
        rep.status = etpq_pkg::ST_POP_EMPTY;
        empty_pop_count++;
      end else begin
        rep.ev = ev_slot[0];
        for (i = 1; i < ev_count; i++)
          ev_slot[i-1] = ev_slot[i];
        ev_count--;
      end
    end
    rep.empty = (ev_count == 0);
    rep.full  = (ev_count >= QDEPTH);
    if (rep.full)
      full_seen++;
    return rep;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on each accepted request, compare each accepted reply
  always @(posedge clk) begin : reply_check
    request_t r;
    reply_t   want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        r.func            = req_ch.func;
        r.ev.kind         = req_ch.event_kind;
        r.ev.etime        = req_ch.event_time;
        r.ev.task_number  = req_ch.task_number;
        r.ev.burst        = req_ch.task_burst;
        r.ev.arrival      = req_ch.task_arrival;
        r.ev.priority_lvl = req_ch.task_priority;
        reply_backlog.push_back(event_queue_step(r));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reply_backlog.size() == 0) begin
          $error("reply with no request outstanding");
          mismatches++;
        end else begin
          want = reply_backlog.pop_front();
          check_field("status", 16'(want.status), 16'(rsp_ch.status));
          check_field("popped_kind", 16'(want.ev.kind), 16'(rsp_ch.popped_kind));
          check_field("popped_time", want.ev.etime, rsp_ch.popped_time);
          check_field("popped_task", 16'(want.ev.task_number), 16'(rsp_ch.popped_task));
          check_field("popped_burst", want.ev.burst, rsp_ch.popped_burst);
          check_field("popped_arrival", want.ev.arrival, rsp_ch.popped_arrival);
          check_field("popped_priority", 16'(want.ev.priority_lvl),
                      16'(rsp_ch.popped_priority));
          check_field("queue_empty", 16'(want.empty), 16'(rsp_ch.queue_empty));
          check_field("queue_full", 16'(want.full), 16'(rsp_ch.queue_full));
        end
      end
    end
  end

  // Reply receiver: random stalls, plus one long hold on request
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin : take_loop
      int stall;
      if (hold_len > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      stall = take_gaps ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Send one request; returns at the edge where it is accepted
  task automatic issue_request(logic func, etpq_pkg::event_t ev);
    int gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.func          = func;
    req_ch.event_kind    = ev.kind;
    req_ch.event_time    = ev.etime;
    req_ch.task_number   = ev.task_number;
    req_ch.task_burst    = ev.burst;
    req_ch.task_arrival  = ev.arrival;
    req_ch.task_priority = ev.priority_lvl;
    req_ch.valid         = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic etpq_pkg::event_t make_event(logic kind, logic [15:0] etime,
                                                  logic [7:0] tnum, logic [15:0] burst,
                                                  logic [15:0] arrival, logic [7:0] prio);
    etpq_pkg::event_t ev;
    ev.kind         = kind;
    ev.etime        = etime;
    ev.task_number  = tnum;
    ev.burst        = burst;
    ev.arrival      = arrival;
    ev.priority_lvl = prio;
    return ev;
  endfunction

  // Random event; times often crowd into small windows to force ties
  function automatic etpq_pkg::event_t rand_event();
    logic [15:0] t;
    case ($urandom_range(0, 3))
      0: t = 16'($urandom_range(0, 7));
      1: t = 16'($urandom_range(65528, 65535));
      default: t = 16'($urandom_range(0, 65535));
    endcase
    return make_event(1'($urandom_range(0, 1)), t, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
  endfunction

  // Extremes of the fields and the tie-break rules, ending empty
  task automatic test_directed_edges();
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    issue_request(etpq_pkg::FUNC_POP, rand_event());
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b0, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b1, 16'h0000, 8'h11, 16'h1234, 16'h5678, 8'h9A));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b0, 16'd100, 8'h01, 16'hAAAA, 16'h5555, 8'h0F));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b0, 16'd100, 8'h02, 16'h5555, 16'hAAAA, 8'hF0));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b1, 16'd100, 8'h03, 16'h00FF, 16'hFF00, 8'h3C));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b0, 16'hFFFF, 8'hFE, 16'h8001, 16'h7FFE, 8'hC3));
    issue_request(etpq_pkg::FUNC_PUSH,
                  make_event(1'b1, 16'd100, 8'h04, 16'h0F0F, 16'hF0F0, 8'h81));
    repeat (9) issue_request(etpq_pkg::FUNC_POP, rand_event());
  endtask

  // Fill past full so pushes drop, then drain past empty
  task automatic test_fill_drain();
    for (int round = 0; round < 4; round++) begin
      send_gaps = round[0];
      take_gaps = round[1];
      repeat (QDEPTH + $urandom_range(1, 3)) issue_request(etpq_pkg::FUNC_PUSH, rand_event());
      repeat (QDEPTH + $urandom_range(1, 2)) issue_request(etpq_pkg::FUNC_POP, rand_event());
    end
  endtask

  // Receiver holds off while the sender keeps pushing back to back
  task automatic test_reply_backpressure();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    hold_len  = HOLD_LEN;
    repeat (QDEPTH + 8) issue_request(etpq_pkg::FUNC_PUSH, rand_event());
    repeat (QDEPTH + 1) issue_request(etpq_pkg::FUNC_POP, rand_event());
  endtask

  // Mixed traffic, push odds steered by fill level, four pacing modes
  task automatic test_random_mix();
    int held;
    int push_pct;
    logic func;
    held = 0;
    for (int seg = 0; seg < 4; seg++) begin
      send_gaps = (seg == 0 || seg == 2);
      take_gaps = (seg == 0 || seg == 3);
      repeat (165) begin
        push_pct = (held < 4) ? 75 : (held > 12) ? 30 : 55;
        func = ($urandom_range(0, 99) < push_pct) ? etpq_pkg::FUNC_PUSH : etpq_pkg::FUNC_POP;
        issue_request(func, rand_event());
        if (func == etpq_pkg::FUNC_PUSH)
          held = (held < QDEPTH) ? held + 1 : held;
        else
          held = (held > 0) ? held - 1 : 0;
      end
    end
  endtask

  // Test sequence
  initial begin
    mismatches = 0;
    push_count = 0;
    pop_count = 0;
    drop_count = 0;
    empty_pop_count = 0;
    full_seen = 0;
    ev_count = 0;
    hold_len = 0;
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);

    test_directed_edges();
    test_fill_drain();
    test_reply_backpressure();
    test_random_mix();

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (reply_backlog.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d pushes (%0d dropped on full) and %0d pops (%0d on empty)",
             push_count, drop_count, pop_count, empty_pop_count);
    $display("Queue reported full after %0d requests; %0d reply mismatches",
             full_seen, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
